// ===== hdl/lfs_pkg.sv =====
// Shared types, codes and constants of the line follower steering block.
package lfs_pkg;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_DECIDE
    } t_state;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Tracking states
    localparam logic [2:0] TRK_FORWARD      = 3'd0;
    localparam logic [2:0] TRK_TURN_LEFT    = 3'd1;
    localparam logic [2:0] TRK_TURN_RIGHT   = 3'd2;
    localparam logic [2:0] TRK_SEARCH_LEFT  = 3'd3;
    localparam logic [2:0] TRK_SEARCH_RIGHT = 3'd4;
    localparam logic [2:0] TRK_INTERSECTION = 3'd5;
    localparam logic [2:0] TRK_STOPPED      = 3'd6;

    // Drive kinds
    localparam logic [1:0] DK_STOP    = 2'd0;
    localparam logic [1:0] DK_FORWARD = 2'd1;
    localparam logic [1:0] DK_TURN    = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_BLACK_LEVEL   = 3'd0;
    localparam logic [2:0] CFG_LOST_STOP_MS  = 3'd1;
    localparam logic [2:0] CFG_DEADBAND_Q8   = 3'd2;
    localparam logic [2:0] CFG_FORWARD_SPEED = 3'd3;
    localparam logic [2:0] CFG_TURN_SPEED    = 3'd4;
    localparam logic [2:0] CFG_SEARCH_SPEED  = 3'd5;

    // Divider geometry: |sum|*256 fits 11 bits, count fits 3 bits
    localparam int DIV_W     = 11;
    localparam int DVS_W     = 3;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Weight of one sensor; bit0 is the rightmost sensor
    function automatic logic signed [3:0] sensor_weight(input logic [1:0] bit_num);
        logic signed [3:0] w;
        case (bit_num)
            2'd0:    w = 4'sd3;
            2'd1:    w = 4'sd1;
            2'd2:    w = -4'sd1;
            default: w = -4'sd3;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/lfs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the line error.
module lfs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lfs_pkg::DIV_W-1:0]   i_dividend,
    input  logic [lfs_pkg::DVS_W-1:0]   i_divisor,
    output logic [lfs_pkg::DIV_W-1:0]   o_quotient,
    output lfs_pkg::t_div_stat          o_stat
);

    logic                            r_busy;
    logic                            r_done;
    logic [lfs_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [lfs_pkg::DVS_W-1:0]       r_rem;
    logic [lfs_pkg::DVS_W-1:0]       r_dvs;
    logic [lfs_pkg::DIV_W-1:0]       r_quo;

    logic [lfs_pkg::DVS_W:0]         trial;
    logic [lfs_pkg::DVS_W:0]         diff;
    logic                            q_bit;
    logic [lfs_pkg::DVS_W-1:0]       n_rem;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[lfs_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        q_bit = (trial >= {1'b0, r_dvs});
        n_rem = q_bit ? diff[lfs_pkg::DVS_W-1:0] : trial[lfs_pkg::DVS_W-1:0];
    end

    // Control: busy for a fixed number of steps, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == lfs_pkg::DIV_CNT_W'(lfs_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: dividend bits leave the top as quotient bits enter the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[lfs_pkg::DIV_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== hdl/line_follower_steering.sv =====
// Top level of the four-sensor line follower steering controller.
// One sensor word is taken at a time: after acceptance the sequencer scans the four sensors
// through one shared adder, runs the 11-step restoring divider for the Q8 line error, and
// then makes the steering decision. The decision state holds while a previous result
// still waits in the output register. s_axis_tready is high only while the sequencer
// is idle. The result sits in an output register, so the next word may be accepted
// while the previous result still waits to be taken.
module line_follower_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    // Sample input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] sensor_levels, [35:4] time_ms, [39:36] zero
    input  logic [39:0] s_axis_tdata,
    // Steering result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] track_state, [4:3] drive_kind, [17:5] drive_speed, [21:18] black_pattern,
    // [24:22] black_total, [35:25] line_error_q8, [39:36] zero
    output logic [39:0] m_axis_tdata
);

    // Configuration registers
    logic        r_black_level;
    logic [15:0] r_lost_stop_ms;
    logic [9:0]  r_deadband_q8;
    logic [11:0] r_forward_speed;
    logic [11:0] r_turn_speed;
    logic [11:0] r_search_speed;

    // Steering state
    logic        r_lost_active;
    logic [31:0] r_lost_start_ms;
    logic        r_last_err_neg;

    // Sequencer and working registers
    lfs_pkg::t_state   r_state, n_state;
    logic [1:0]        r_idx;
    logic [3:0]        r_pattern;
    logic [31:0]       r_now;
    logic signed [3:0] r_sum;
    logic [2:0]        r_count;

    // Output register
    logic        r_out_valid;
    logic [39:0] r_out_data;

    logic signed [3:0] n_sum;
    logic [2:0]        n_count;
    logic [2:0]        sum_mag;
    logic              div_start;
    logic              accept;
    logic              load_out;
    logic [lfs_pkg::DIV_W-1:0] quotient;
    lfs_pkg::t_div_stat        div_stat;

    // Decision signals
    logic [31:0]        elapsed;
    logic               stop_now;
    logic signed [13:0] lhs;
    logic signed [13:0] band;
    logic [2:0]         trk;
    logic [1:0]         kind;
    logic signed [12:0] speed;
    logic signed [10:0] err;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == lfs_pkg::S_IDLE);

    // Shared adder: fold in one sensor per scan cycle
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (r_pattern[r_idx]) begin
            n_sum   = r_sum + lfs_pkg::sensor_weight(r_idx);
            n_count = r_count + 3'd1;
        end
        sum_mag = n_sum[3] ? 3'(-n_sum) : n_sum[2:0];
    end

    assign div_start = (r_state == lfs_pkg::S_SCAN) && (r_idx == 2'd3);

    lfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({sum_mag, 8'd0}),
        .i_divisor  (n_count),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    // Steering decision from the finished scan and division
    always_comb begin
        elapsed  = r_lost_active ? (r_now - r_lost_start_ms) : 32'd0;
        stop_now = (elapsed >= {16'd0, r_lost_stop_ms});
        lhs      = 14'(r_sum) <<< 8;
        band     = $signed({1'b0, 13'({3'd0, r_deadband_q8} * {10'd0, r_count})});
        err      = (r_count == 3'd0) ? 11'sd0
                 : (r_sum[3] ? -$signed(quotient) : $signed(quotient));
        if (r_count == 3'd0) begin
            if (stop_now) begin
                trk = lfs_pkg::TRK_STOPPED; kind = lfs_pkg::DK_STOP; speed = 13'sd0;
            end else if (r_last_err_neg) begin
                trk   = lfs_pkg::TRK_SEARCH_LEFT; kind = lfs_pkg::DK_TURN;
                speed = $signed({1'b0, r_search_speed});
            end else begin
                trk   = lfs_pkg::TRK_SEARCH_RIGHT; kind = lfs_pkg::DK_TURN;
                speed = -$signed({1'b0, r_search_speed});
            end
        end else if (r_count == 3'd4) begin
            trk   = lfs_pkg::TRK_INTERSECTION; kind = lfs_pkg::DK_FORWARD;
            speed = $signed({1'b0, r_forward_speed});
        end else if (lhs < -band) begin
            trk   = lfs_pkg::TRK_TURN_LEFT; kind = lfs_pkg::DK_TURN;
            speed = $signed({1'b0, r_turn_speed});
        end else if (lhs > band) begin
            trk   = lfs_pkg::TRK_TURN_RIGHT; kind = lfs_pkg::DK_TURN;
            speed = -$signed({1'b0, r_turn_speed});
        end else begin
            trk   = lfs_pkg::TRK_FORWARD; kind = lfs_pkg::DK_FORWARD;
            speed = $signed({1'b0, r_forward_speed});
        end
    end

    // Next state: load the result once the output register is free
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            lfs_pkg::S_IDLE:   if (accept) n_state = lfs_pkg::S_SCAN;
            lfs_pkg::S_SCAN:   if (r_idx == 2'd3) n_state = lfs_pkg::S_DIV;
            lfs_pkg::S_DIV:    if (div_stat.done) n_state = lfs_pkg::S_DECIDE;
            lfs_pkg::S_DECIDE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = lfs_pkg::S_IDLE;
                end
            end
            default:           n_state = lfs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lfs_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_level   <= 1'b1;
            r_lost_stop_ms  <= 16'd1200;
            r_deadband_q8   <= 10'd115;
            r_forward_speed <= 12'd220;
            r_turn_speed    <= 12'd1800;
            r_search_speed  <= 12'd1200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lfs_pkg::CFG_BLACK_LEVEL:   r_black_level   <= i_cfg_data[0];
                lfs_pkg::CFG_LOST_STOP_MS:  r_lost_stop_ms  <= i_cfg_data;
                lfs_pkg::CFG_DEADBAND_Q8:   r_deadband_q8   <= i_cfg_data[9:0];
                lfs_pkg::CFG_FORWARD_SPEED: r_forward_speed <= i_cfg_data[11:0];
                lfs_pkg::CFG_TURN_SPEED:    r_turn_speed    <= i_cfg_data[11:0];
                lfs_pkg::CFG_SEARCH_SPEED:  r_search_speed  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Capture the sample, then advance the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (accept) begin
            r_idx <= 2'd0;
        end else if (r_state == lfs_pkg::S_SCAN) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pattern <= r_black_level ? s_axis_tdata[3:0] : ~s_axis_tdata[3:0];
            r_now     <= s_axis_tdata[35:4];
            r_sum     <= 4'sd0;
            r_count   <= 3'd0;
        end else if (r_state == lfs_pkg::S_SCAN) begin
            r_sum     <= n_sum;
            r_count   <= n_count;
        end
    end

    // Update the lost timer and last error side when the result is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_active   <= 1'b0;
            r_lost_start_ms <= 32'd0;
            r_last_err_neg  <= 1'b0;
        end else if (load_out) begin
            if (r_count == 3'd0) begin
                r_lost_active <= 1'b1;
                if (!r_lost_active) r_lost_start_ms <= r_now;
            end else begin
                r_lost_active <= 1'b0;
                if (r_count != 3'd4) r_last_err_neg <= r_sum[3];
            end
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {4'd0, err, r_count, r_pattern, speed, kind, trk};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == lfs_pkg::S_DIV))
        else $error("divider running outside division state");

    a_lost_has_no_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == lfs_pkg::TRK_STOPPED
            || m_axis_tdata[2:0] == lfs_pkg::TRK_SEARCH_LEFT
            || m_axis_tdata[2:0] == lfs_pkg::TRK_SEARCH_RIGHT))
        |-> (m_axis_tdata[24:22] == 3'd0))
        else $error("search or stop with black sensors");

    a_intersection_all_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] == lfs_pkg::TRK_INTERSECTION)
        |-> (m_axis_tdata[21:18] == 4'hF))
        else $error("intersection without all sensors black");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !load_out)
        else $error("result overwritten before taken");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for line_follower_steering: sensor words checked field by field against a predictor.
module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int GAP_MAX     = 13;

    // Register indexes past the end of the map; writes there must change nothing
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // One steering result as the block reports it
    typedef struct packed {
        logic [2:0]         track;
        logic [1:0]         kind;
        logic signed [12:0] speed;
        logic [3:0]         pattern;
        logic [2:0]         total;
        logic signed [10:0] err_q8;
    } t_steer;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [3:0] sensor_levels, [35:4] time_ms, [39:36] zero
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [2:0] track_state, [4:3] drive_kind, [17:5] drive_speed, [21:18] black_pattern,
    // [24:22] black_total, [35:25] line_error_q8, [39:36] zero
    logic [39:0] m_axis_tdata;

    // Register copies
    logic        reg_black;
    logic [15:0] reg_lost_ms;
    logic [9:0]  reg_deadband;
    logic [11:0] reg_fwd;
    logic [11:0] reg_turn;
    logic [11:0] reg_search;

    // Tracking state copies
    logic        line_lost;
    logic [31:0] lost_since;
    logic        last_left;

    t_steer pending_steer[$];
    int     n_fail      = 0;
    int     n_samples   = 0;
    int     n_results   = 0;
    int     cycle_count = 0;
    int     track_seen [0:6];
    bit     tx_burst    = 1'b0;
    bit     rx_burst    = 1'b0;

    line_follower_steering uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Work out the steering result of one sample and advance the tracking state
    function automatic t_steer predict_steering(input logic [3:0] levels,
                                                input logic [31:0] now);
        t_steer      r;
        logic [3:0]  pat;
        logic [31:0] elapsed;
        int          sum;
        int          cnt;
        int          err;
        int          band;
        int          spd;
        pat = reg_black ? levels : ~levels;
        sum = 0;
        cnt = 0;
        err = 0;
        spd = 0;
        for (int b = 0; b < 4; b++) begin
            if (pat[b]) begin
                // bit0 is the rightmost sensor
                case (b)
                    0: sum += 3;
                    1: sum += 1;
                    2: sum -= 1;
                    default: sum -= 3;
                endcase
                cnt++;
            end
        end
        if (cnt != 0)
            err = (sum * 256) / cnt;
        r.pattern = pat;
        r.total   = cnt[2:0];
        r.err_q8  = err[10:0];

        if (cnt == 0) begin
            // Line lost: start the timer on the first white sample
            if (!line_lost) begin
                line_lost  = 1'b1;
                lost_since = now;
            end
            elapsed = now - lost_since;
            if (elapsed >= {16'd0, reg_lost_ms}) begin
                r.track = lfs_pkg::TRK_STOPPED;
                r.kind  = lfs_pkg::DK_STOP;
            end else if (last_left) begin
                r.track = lfs_pkg::TRK_SEARCH_LEFT;
                r.kind  = lfs_pkg::DK_TURN;
                spd     = int'(reg_search);
            end else begin
                r.track = lfs_pkg::TRK_SEARCH_RIGHT;
                r.kind  = lfs_pkg::DK_TURN;
                spd     = -int'(reg_search);
            end
        end else begin
            line_lost = 1'b0;
            if (cnt == 4) begin
                // Intersection keeps the last error side
                r.track = lfs_pkg::TRK_INTERSECTION;
                r.kind  = lfs_pkg::DK_FORWARD;
                spd     = int'(reg_fwd);
            end else begin
                band      = int'(reg_deadband) * cnt;
                last_left = (sum < 0);
                if (sum * 256 < -band) begin
                    r.track = lfs_pkg::TRK_TURN_LEFT;
                    r.kind  = lfs_pkg::DK_TURN;
                    spd     = int'(reg_turn);
                end else if (sum * 256 > band) begin
                    r.track = lfs_pkg::TRK_TURN_RIGHT;
                    r.kind  = lfs_pkg::DK_TURN;
                    spd     = -int'(reg_turn);
                end else begin
                    r.track = lfs_pkg::TRK_FORWARD;
                    r.kind  = lfs_pkg::DK_FORWARD;
                    spd     = int'(reg_fwd);
                end
            end
        end
        r.speed = spd[12:0];
        return r;
    endfunction

    // Send one sensor word and queue its expected result once accepted
    task automatic send_sample(input logic [3:0] levels, input logic [31:0] now);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, now, levels};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_steer.push_back(predict_steering(levels, now));
        n_samples++;
    endtask

    // Hold the input side until every queued result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_steer.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register and mirror it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            lfs_pkg::CFG_BLACK_LEVEL:   reg_black    = value[0];
            lfs_pkg::CFG_LOST_STOP_MS:  reg_lost_ms  = value;
            lfs_pkg::CFG_DEADBAND_Q8:   reg_deadband = value[9:0];
            lfs_pkg::CFG_FORWARD_SPEED: reg_fwd      = value[11:0];
            lfs_pkg::CFG_TURN_SPEED:    reg_turn     = value[11:0];
            lfs_pkg::CFG_SEARCH_SPEED:  reg_search   = value[11:0];
            default: ;
        endcase
    endtask

    task automatic set_steering(input logic blk, input logic [15:0] lost_ms,
                                input logic [15:0] dead, input logic [15:0] fwd,
                                input logic [15:0] turn, input logic [15:0] search);
        write_reg(lfs_pkg::CFG_BLACK_LEVEL, {15'd0, blk});
        write_reg(lfs_pkg::CFG_LOST_STOP_MS, lost_ms);
        write_reg(lfs_pkg::CFG_DEADBAND_Q8, dead);
        write_reg(lfs_pkg::CFG_FORWARD_SPEED, fwd);
        write_reg(lfs_pkg::CFG_TURN_SPEED, turn);
        write_reg(lfs_pkg::CFG_SEARCH_SPEED, search);
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            n_fail++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Reset register values: single, pair, triple, full and empty patterns, lost timer, wrap and search side
    task automatic test_directed_tracking();
        send_sample(4'b1000, 32'd0);
        send_sample(4'b0001, 32'd10);
        send_sample(4'b0100, 32'd20);
        send_sample(4'b0110, 32'd40);
        send_sample(4'b1100, 32'd50);
        send_sample(4'b0111, 32'd60);
        send_sample(4'b1111, 32'd70);
        // Lost after a right-side error: search right, then stop at the limit
        send_sample(4'b0000, 32'd80);
        send_sample(4'b0000, 32'd1279);
        send_sample(4'b0000, 32'd1280);
        // Left error survives an intersection
        send_sample(4'b1110, 32'd1300);
        send_sample(4'b1111, 32'd1310);
        // Loss across the timestamp wrap
        send_sample(4'b0000, 32'hFFFF_FF00);
        send_sample(4'b0000, 32'h0000_03B0);
        send_sample(4'b0000, 32'hFFFF_FFFF);
        // Zero error clears the left side
        send_sample(4'b1001, 32'd0);
        send_sample(4'b0000, 32'd5);
    endtask

    // Deadband equality, zero and full limits, inverted level, masking, spare indexes
    task automatic test_register_extremes();
        drain_results();
        write_reg(lfs_pkg::CFG_DEADBAND_Q8, 16'd256);
        send_sample(4'b0100, 32'd100);
        drain_results();
        write_reg(lfs_pkg::CFG_DEADBAND_Q8, 16'd768);
        send_sample(4'b1000, 32'd110);
        send_sample(4'b0001, 32'd120);
        drain_results();
        write_reg(lfs_pkg::CFG_DEADBAND_Q8, 16'hFFFF);
        send_sample(4'b0011, 32'd130);
        drain_results();
        write_reg(lfs_pkg::CFG_LOST_STOP_MS, 16'd0);
        send_sample(4'b0000, 32'd140);
        drain_results();
        write_reg(lfs_pkg::CFG_BLACK_LEVEL, 16'hFFFE);
        write_reg(lfs_pkg::CFG_DEADBAND_Q8, 16'd0);
        write_reg(lfs_pkg::CFG_TURN_SPEED, 16'd4095);
        write_reg(lfs_pkg::CFG_FORWARD_SPEED, 16'd0);
        send_sample(4'b0111, 32'd150);
        send_sample(4'b1111, 32'd160);
        send_sample(4'b0000, 32'd170);
        drain_results();
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        write_reg(lfs_pkg::CFG_SEARCH_SPEED, 16'd4095);
        write_reg(lfs_pkg::CFG_LOST_STOP_MS, 16'hFFFF);
        send_sample(4'b1111, 32'd180);
        send_sample(4'b1111, 32'd180 + 32'd65534);
        send_sample(4'b1111, 32'd180 + 32'd65535);
    endtask

    // Runs of on-line, lost and crossing samples with a running clock, plus noise
    task automatic test_random_tracking(input int n_phases, input int per_phase);
        logic [31:0] now;
        logic [3:0]  pat;
        int          sent;
        int          seg_len;
        int          seg_kind;
        int          step_max;
        bit          paused;
        paused = 1'b0;
        for (int ph = 0; ph < n_phases; ph++) begin
            drain_results();
            case (ph)
                0: set_steering(1'b1, 16'd1200, 16'd115, 16'd220, 16'd1800, 16'd1200);
                1: set_steering(1'b0, 16'd0, 16'd0, 16'd4095, 16'd4095, 16'd4095);
                2: set_steering(1'b1, 16'hFFFF, 16'd768, 16'd0, 16'd0, 16'd0);
                3: set_steering(1'($urandom_range(0, 1)), 16'd1, 16'd1023,
                                16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                                16'($urandom_range(0, 4095)));
                default: set_steering(1'($urandom_range(0, 1)),
                                      ($urandom_range(0, 3) == 0)
                                          ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 3000)),
                                      16'($urandom_range(0, 1023)),
                                      16'($urandom_range(0, 4095)),
                                      16'($urandom_range(0, 4095)),
                                      16'($urandom_range(0, 4095)));
            endcase
            now      = (ph == 2) ? 32'hFFFF_0000 : $urandom;
            step_max = reg_lost_ms / 3 + 2;
            sent     = 0;
            while (sent < per_phase) begin
                // Let the pipeline empty once, in the middle of phase 4
                if (ph == 4 && !paused && sent >= per_phase / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                seg_kind = $urandom_range(0, 99);
                seg_len  = $urandom_range(1, 10);
                tx_burst = ($urandom_range(0, 4) == 0);
                rx_burst = ($urandom_range(0, 4) == 0);
                for (int k = 0; k < seg_len && sent < per_phase; k++) begin
                    now = now + $urandom_range(0, step_max);
                    if (seg_kind < 45) begin
                        pat = 4'($urandom_range(1, 14));
                    end else if (seg_kind < 75) begin
                        pat = 4'h0;
                    end else if (seg_kind < 82) begin
                        pat = 4'hF;
                    end else begin
                        pat = 4'($urandom_range(0, 15));
                        now = $urandom;
                    end
                    send_sample(reg_black ? pat : ~pat, now);
                    sent++;
                end
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Take results with random stalls and check each against the oldest expectation
    initial begin : result_checker
        t_steer want;
        int     stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            if (pending_steer.size() == 0) begin
                n_fail++;
                $error("unexpected steering word 0x%0h", m_axis_tdata);
            end else begin
                want = pending_steer.pop_front();
                report_field("track_state", int'(want.track), int'(m_axis_tdata[2:0]));
                report_field("drive_kind", int'(want.kind), int'(m_axis_tdata[4:3]));
                report_field("drive_speed", int'(want.speed),
                             int'($signed(m_axis_tdata[17:5])));
                report_field("black_pattern", int'(want.pattern), int'(m_axis_tdata[21:18]));
                report_field("black_total", int'(want.total), int'(m_axis_tdata[24:22]));
                report_field("line_error_q8", int'(want.err_q8),
                             int'($signed(m_axis_tdata[35:25])));
                track_seen[want.track]++;
                n_results++;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= lfs_pkg::CFG_BLACK_LEVEL;
        i_cfg_data    <= 16'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 40'd0;
        reg_black     = 1'b1;
        reg_lost_ms   = 16'd1200;
        reg_deadband  = 10'd115;
        reg_fwd       = 12'd220;
        reg_turn      = 12'd1800;
        reg_search    = 12'd1200;
        line_lost     = 1'b0;
        lost_since    = 32'd0;
        last_left     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_tracking();
        test_register_extremes();
        test_random_tracking(7, 155);

        // Wait out the last results, then report
        drain_results();
        repeat (30) @(posedge i_clk);
        $display("Checked %0d steering words from %0d samples over seven register settings",
                 n_results, n_samples);
        $display("Forward %0d, turns %0d, searches %0d, intersections %0d, stops %0d",
                 track_seen[lfs_pkg::TRK_FORWARD],
                 track_seen[lfs_pkg::TRK_TURN_LEFT] + track_seen[lfs_pkg::TRK_TURN_RIGHT],
                 track_seen[lfs_pkg::TRK_SEARCH_LEFT] + track_seen[lfs_pkg::TRK_SEARCH_RIGHT],
                 track_seen[lfs_pkg::TRK_INTERSECTION], track_seen[lfs_pkg::TRK_STOPPED]);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== line_follower_steering.f =====
hdl/lfs_pkg.sv
hdl/lfs_div.sv
hdl/line_follower_steering.sv
tb/sv/tb_top.sv
